@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`endif

@@ rtl/core/hsfd_pkg.sv @@
package hsfd_pkg;

    // Frame status codes
    localparam logic [1:0] ST_NONE       = 2'd0;
    localparam logic [1:0] ST_FRAME_SIZE = 2'd1;
    localparam logic [1:0] ST_PROTOCOL   = 2'd2;
    localparam logic [1:0] ST_FLOW       = 2'd3;

    // Byte position of the last byte of a six-byte entry
    localparam logic [2:0] ENTRY_LAST_POS = 3'd5;

    localparam logic [31:0] WINDOW_MAX = 32'd2147483647;
    localparam logic [31:0] FSIZE_MIN  = 32'd16384;
    localparam logic [31:0] FSIZE_MAX  = 32'd16777215;

    localparam logic [31:0] RST_TABLE_SIZE = 32'd4096;
    localparam logic [30:0] RST_WINDOW     = 31'd65535;
    localparam logic [23:0] RST_FRAME_SIZE = 24'd16384;
    localparam logic [31:0] RST_ALL_ONES   = 32'hFFFF_FFFF;

    localparam int OUT_DATA_W = 160;

    typedef enum logic [2:0] {
        SET_NONE    = 3'd0,
        SET_TABLE   = 3'd1,
        SET_PUSH    = 3'd2,
        SET_STREAMS = 3'd3,
        SET_WINDOW  = 3'd4,
        SET_FSIZE   = 3'd5,
        SET_LIST    = 3'd6
    } t_set_id;

    // One queued operation: an optional setting update and an optional end of frame
    typedef struct packed {
        logic        upd;
        t_set_id     sel;
        logic [31:0] value;
        logic        last;
        logic [1:0]  status;
    } t_op;

endpackage

@@ rtl/core/http2_settings_frame_decoder.sv @@
// Path: with the queue empty, a frame's result is written to the queue at the edge that
// accepts the item carrying tlast, then to the output register once the output slot is free.
// Throughput: one item per cycle while the two-entry queue is not full, else s_axis_tready is low;
// the queue absorbs short output stalls.
// Reset (i_rst_n low at a clock edge): settings return to their protocol defaults,
// the entry assembler, queue and output register empty.
module http2_settings_frame_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [7:0] payload_byte
    input  logic [0:0]   s_axis_tuser,  // [0] byte_valid
    input  logic         s_axis_tlast,  // frame_end
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] status, [33:2] table_size, [34] push_enable,
    // [66:35] stream_limit, [97:67] window_size,
    // [121:98] frame_limit, [153:122] list_limit, [159:154] zero
    output logic [hsfd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import hsfd_pkg::*;
    `include "assert_macros.svh"

    logic        q_full;
    logic        q_push;
    t_op         f_op;
    logic        q_valid;
    logic        q_pop;
    t_op         q_op;
    logic [1:0]  b_status;
    logic [31:0] b_table;
    logic        b_push_en;
    logic [31:0] b_streams;
    logic [30:0] b_window;
    logic [23:0] b_fsize;
    logic [31:0] b_list;

    hsfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_byte_valid (s_axis_tuser[0]),
        .i_frame_end  (s_axis_tlast),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_op         (f_op)
    );

    hsfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (f_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    hsfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (q_op),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_status  (b_status),
        .o_table   (b_table),
        .o_push_en (b_push_en),
        .o_streams (b_streams),
        .o_window  (b_window),
        .o_fsize   (b_fsize),
        .o_list    (b_list)
    );

    assign m_axis_tdata = {6'd0, b_list, b_fsize, b_window, b_streams, b_push_en,
                           b_table, b_status};

    // an accepted end of frame is either queued or already on the output next cycle
    `ASSERT_CLK(a_end_tracked, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> q_valid || m_axis_tvalid)
    // the reported frame size setting never falls below its minimum
    `ASSERT_NEVER(a_fsize_low, i_clk, i_rst_n, m_axis_tvalid && (b_fsize < FSIZE_MIN[23:0]))
    // a queued end of frame is not dropped while the output is stalled
    `ASSERT_NEVER(a_no_end_pop_stalled, i_clk, i_rst_n, q_pop && q_op.last && m_axis_tvalid && !m_axis_tready)

endmodule

@@ rtl/core/hsfd_front.sv @@
module hsfd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_byte_valid,
    input  logic           i_frame_end,
    input  logic           i_q_full,
    output logic           o_push,
    output hsfd_pkg::t_op  o_op
);
    import hsfd_pkg::*;

    logic [2:0]  r_pos,  n_pos;
    logic [39:0] r_buf,  n_buf;
    logic [1:0]  r_err,  n_err;

    assign o_ready = !i_q_full;

    always_comb begin
        logic        accept;
        logic [15:0] id;
        logic [31:0] val;
        logic [1:0]  chk;
        t_set_id     sel;
        t_op         op;

        accept = i_valid && !i_q_full;
        id     = r_buf[39:24];
        val    = {r_buf[23:0], i_byte};
        n_pos  = r_pos;
        n_buf  = r_buf;
        n_err  = r_err;
        op     = '0;
        chk    = ST_NONE;

        unique case (id)
            16'd1:   sel = SET_TABLE;
            16'd2:   sel = SET_PUSH;
            16'd3:   sel = SET_STREAMS;
            16'd4:   sel = SET_WINDOW;
            16'd5:   sel = SET_FSIZE;
            16'd6:   sel = SET_LIST;
            default: sel = SET_NONE;
        endcase

        case (sel)
            SET_PUSH:   if (val > 32'd1) chk = ST_PROTOCOL;
            SET_WINDOW: if (val > WINDOW_MAX) chk = ST_FLOW;
            SET_FSIZE:  if (val < FSIZE_MIN || val > FSIZE_MAX) chk = ST_PROTOCOL;
            default:    chk = ST_NONE;
        endcase

        if (accept) begin
            if (i_byte_valid && r_err == ST_NONE) begin
                if (r_pos != ENTRY_LAST_POS) begin
                    n_buf = {r_buf[31:0], i_byte};
                    n_pos = r_pos + 3'd1;
                end else begin
                    // entry complete: latch a range error, else forward the update
                    if (chk != ST_NONE) begin
                        n_err = chk;
                    end else if (sel != SET_NONE) begin
                        op.upd   = 1'b1;
                        op.sel   = sel;
                        op.value = val;
                    end
                    n_pos = 3'd0;
                end
            end
            if (i_frame_end) begin
                op.last   = 1'b1;
                op.status = (n_err == ST_NONE && n_pos != 3'd0) ? ST_FRAME_SIZE : n_err;
                n_pos     = 3'd0;
                n_err     = ST_NONE;
            end
        end

        o_op   = op;
        o_push = op.upd || op.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
            r_err <= ST_NONE;
        end else begin
            r_pos <= n_pos;
            r_err <= n_err;
        end
        r_buf <= n_buf;
    end

endmodule

@@ rtl/core/hsfd_queue.sv @@
module hsfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hsfd_pkg::t_op  i_op,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output hsfd_pkg::t_op  o_op
);
    import hsfd_pkg::*;

    t_op        r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
        if (do_push) r_mem[r_wr_ptr] <= i_op;
    end

endmodule

@@ rtl/core/hsfd_back.sv @@
module hsfd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  hsfd_pkg::t_op  i_op,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_status,
    output logic [31:0]    o_table,
    output logic           o_push_en,
    output logic [31:0]    o_streams,
    output logic [30:0]    o_window,
    output logic [23:0]    o_fsize,
    output logic [31:0]    o_list
);
    import hsfd_pkg::*;

    logic [31:0] r_table,   n_table;
    logic        r_push,    n_push;
    logic [31:0] r_streams, n_streams;
    logic [30:0] r_window,  n_window;
    logic [23:0] r_fsize,   n_fsize;
    logic [31:0] r_list,    n_list;
    logic        r_out_valid;
    logic        out_free;

    assign out_free = !r_out_valid || i_ready;
    // updates never wait unless they carry an end of frame, which waits for the output slot
    assign o_pop    = i_q_valid && (!i_op.last || out_free);

    always_comb begin
        n_table   = r_table;
        n_push    = r_push;
        n_streams = r_streams;
        n_window  = r_window;
        n_fsize   = r_fsize;
        n_list    = r_list;
        if (o_pop && i_op.upd) begin
            case (i_op.sel)
                SET_TABLE:   n_table   = i_op.value;
                SET_PUSH:    n_push    = i_op.value[0];
                SET_STREAMS: n_streams = i_op.value;
                SET_WINDOW:  n_window  = i_op.value[30:0];
                SET_FSIZE:   n_fsize   = i_op.value[23:0];
                SET_LIST:    n_list    = i_op.value;
                default:     n_table   = r_table;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table     <= RST_TABLE_SIZE;
            r_push      <= 1'b1;
            r_streams   <= RST_ALL_ONES;
            r_window    <= RST_WINDOW;
            r_fsize     <= RST_FRAME_SIZE;
            r_list      <= RST_ALL_ONES;
            r_out_valid <= 1'b0;
        end else begin
            r_table   <= n_table;
            r_push    <= n_push;
            r_streams <= n_streams;
            r_window  <= n_window;
            r_fsize   <= n_fsize;
            r_list    <= n_list;
            if (o_pop && i_op.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        // snapshot the settings as they stand after this item
        if (o_pop && i_op.last) begin
            o_status  <= i_op.status;
            o_table   <= n_table;
            o_push_en <= n_push;
            o_streams <= n_streams;
            o_window  <= n_window;
            o_fsize   <= n_fsize;
            o_list    <= n_list;
        end
    end

    assign o_valid = r_out_valid;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import hsfd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 490;

    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       eof;
    } t_pay_item;

    // Mirrors the packing of m_axis_tdata, lowest field last
    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] max_hlist;
        logic [23:0] max_fsize;
        logic [30:0] init_win;
        logic [31:0] max_streams;
        logic        push_en;
        logic [31:0] hdr_tbl;
        logic [1:0]  status;
    } t_settings_rpt;

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;  // [7:0] payload_byte
    logic [0:0]   s_axis_tuser = 1'b0;   // [0] byte_valid
    logic         s_axis_tlast = 1'b0;   // frame_end
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [1:0] status, [33:2] table_size, [34] push_enable,
    // [66:35] stream_limit, [97:67] window_size,
    // [121:98] frame_limit, [153:122] list_limit, [159:154] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_pay_item     payload_q[$];
    t_settings_rpt settings_reports_q[$];
    int            n_items = 0;
    int            mismatches = 0;
    int            cycles = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    // Decoder state as seen by the testbench
    logic [2:0]  asm_pos = 3'd0;
    logic [39:0] asm_buf = 40'd0;
    logic [1:0]  frm_err = ST_NONE;
    logic [31:0] hdr_tbl_q = RST_TABLE_SIZE;
    logic        push_q = 1'b1;
    logic [31:0] streams_q = RST_ALL_ONES;
    logic [30:0] win_q = RST_WINDOW;
    logic [23:0] fsize_q = RST_FRAME_SIZE;
    logic [31:0] hlist_q = RST_ALL_ONES;

    http2_settings_frame_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [1:0] apply_setting(logic [15:0] id, logic [31:0] val);
        t_set_id sel;
        if (id[15:3] != 13'd0) return ST_NONE;
        sel = t_set_id'(id[2:0]);
        case (sel)
            SET_TABLE: hdr_tbl_q = val;
            SET_PUSH: begin
                if (val > 32'd1) return ST_PROTOCOL;
                push_q = val[0];
            end
            SET_STREAMS: streams_q = val;
            SET_WINDOW: begin
                if (val > WINDOW_MAX) return ST_FLOW;
                win_q = val[30:0];
            end
            SET_FSIZE: begin
                if (val < FSIZE_MIN || val > FSIZE_MAX) return ST_PROTOCOL;
                fsize_q = val[23:0];
            end
            SET_LIST: hlist_q = val;
            default: ;
        endcase
        return ST_NONE;
    endfunction

    // Advance the decoder by one item; return 1 with the frame report on an end mark
    function automatic bit decode_settings_item(t_pay_item it, output t_settings_rpt rpt);
        rpt = '0;
        if (it.has_byte && frm_err == ST_NONE) begin
            if (asm_pos < ENTRY_LAST_POS) begin
                asm_buf = {asm_buf[31:0], it.data};
                asm_pos = asm_pos + 3'd1;
            end else begin
                frm_err = apply_setting(asm_buf[39:24], {asm_buf[23:0], it.data});
                asm_pos = 3'd0;
                asm_buf = 40'd0;
            end
        end
        if (!it.eof) return 1'b0;
        // flag an unfinished entry as a frame size error
        if (frm_err == ST_NONE && asm_pos != 3'd0) frm_err = ST_FRAME_SIZE;
        rpt.status      = frm_err;
        rpt.hdr_tbl     = hdr_tbl_q;
        rpt.push_en     = push_q;
        rpt.max_streams = streams_q;
        rpt.init_win    = win_q;
        rpt.max_fsize   = fsize_q;
        rpt.max_hlist   = hlist_q;
        asm_pos = 3'd0;
        asm_buf = 40'd0;
        frm_err = ST_NONE;
        return 1'b1;
    endfunction

    function automatic void check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, exp_v, act_v);
            mismatches++;
        end
    endfunction

    task automatic put(logic [7:0] data, logic has_byte, logic eof);
        t_pay_item it;
        it.data = data;
        it.has_byte = has_byte;
        it.eof = eof;
        payload_q.insert(payload_q.size(), it);
        if (has_byte || eof) n_items++;
    endtask

    // Queue the first nbytes of one entry, with the end mark on its last byte if asked
    task automatic put_entry(logic [15:0] id, logic [31:0] val, int nbytes, bit end_here);
        logic [47:0] raw;
        raw = {id, val};
        for (int k = 0; k < nbytes; k++)
            put(raw[47 - 8*k -: 8], 1'b1, end_here && (k == nbytes - 1));
    endtask

    function automatic logic [15:0] pick_id();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return 16'd0;
            1: return 16'd7;
            2: return 16'($urandom);
            3: return {8'($urandom_range(1, 255)), 5'd0, 3'($urandom_range(1, 6))};
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [31:0] pick_value(logic [15:0] id);
        int r;
        r = $urandom_range(0, 9);
        if (id[15:3] != 13'd0) return $urandom;
        case (t_set_id'(id[2:0]))
            SET_PUSH: begin
                if (r < 7) return 32'($urandom_range(0, 1));
                if (r == 7) return 32'd2;
                if (r == 8) return RST_ALL_ONES;
                return $urandom;
            end
            SET_WINDOW: begin
                if (r < 5) return $urandom & WINDOW_MAX;
                if (r == 5) return 32'd0;
                if (r == 6) return WINDOW_MAX;
                if (r == 7) return WINDOW_MAX + 32'd1;
                if (r == 8) return RST_ALL_ONES;
                return $urandom;
            end
            SET_FSIZE: begin
                if (r < 5) return $urandom_range(FSIZE_MIN, FSIZE_MAX);
                if (r == 5) return FSIZE_MIN;
                if (r == 6) return FSIZE_MAX;
                if (r == 7) return FSIZE_MIN - 32'd1;
                if (r == 8) return FSIZE_MAX + 32'd1;
                return $urandom;
            end
            default: begin
                if (r < 7) return $urandom;
                if (r == 7) return 32'd0;
                if (r == 8) return RST_ALL_ONES;
                return 32'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic put_frame();
        int  n_ent;
        int  nbytes;
        bit  trunc;
        bit  sep_end;
        logic [15:0] id;
        // occasionally a frame of raw garbage
        if ($urandom_range(0, 19) == 0) begin
            n_ent = $urandom_range(1, 20);
            for (int k = 0; k < n_ent; k++) put(8'($urandom), 1'($urandom), 1'b0);
            put(8'($urandom), 1'($urandom), 1'b1);
            return;
        end
        n_ent   = $urandom_range(0, 5);
        trunc   = ($urandom_range(0, 9) == 0);
        sep_end = 1'($urandom_range(0, 1));
        if (trunc && n_ent == 0) n_ent = 1;
        for (int e = 0; e < n_ent; e++) begin
            if ($urandom_range(0, 7) == 0) put(8'($urandom), 1'b0, 1'b0);
            id = pick_id();
            nbytes = (trunc && e == n_ent - 1) ? $urandom_range(1, 5) : 6;
            put_entry(id, pick_value(id), nbytes, (e == n_ent - 1) && !sep_end);
        end
        if (n_ent == 0 || sep_end) put(8'($urandom), 1'b0, 1'b1);
    endtask

    // Stimulus driver
    always @(posedge i_clk) begin : driver
        t_pay_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (payload_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                it = payload_q.pop_front();
                s_axis_tdata  <= it.data;
                s_axis_tuser  <= it.has_byte;
                s_axis_tlast  <= it.eof;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Predict on accepted input items, check accepted results
    always @(posedge i_clk) begin : monitor
        t_pay_item     acc;
        t_settings_rpt want;
        t_settings_rpt got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                acc.data = s_axis_tdata;
                acc.has_byte = s_axis_tuser[0];
                acc.eof = s_axis_tlast;
                if (decode_settings_item(acc, want))
                    settings_reports_q.insert(settings_reports_q.size(), want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (settings_reports_q.size() == 0) begin
                    $error("result with no frame pending, status %0d", got.status);
                    mismatches++;
                end else begin
                    want = settings_reports_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("table_size", want.hdr_tbl, got.hdr_tbl);
                    check_field("push_enable", want.push_en, got.push_en);
                    check_field("stream_limit", want.max_streams, got.max_streams);
                    check_field("window_size", want.init_win, got.init_win);
                    check_field("frame_limit", want.max_fsize, got.max_fsize);
                    check_field("list_limit", want.max_hlist, got.max_hlist);
                    check_field("pad", want.pad, got.pad);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int target;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty frame
        put(8'hA5, 1'b0, 1'b1);
        // bad push value, then bytes that must be discarded
        put_entry({13'd0, SET_PUSH}, 32'd2, 6, 1'b0);
        put(8'hFF, 1'b1, 1'b0);
        put(8'h00, 1'b0, 1'b1);
        // window one past the limit, end mark on the last byte
        put_entry({13'd0, SET_WINDOW}, WINDOW_MAX + 32'd1, 6, 1'b1);
        // largest frame size, then a trailing partial entry
        put_entry({13'd0, SET_FSIZE}, FSIZE_MAX, 6, 1'b0);
        put(8'h00, 1'b1, 1'b0);
        put(8'hFF, 1'b1, 1'b1);
        while (payload_q.size() != 0) @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            target = n_items + PHASE_ITEMS;
            while (n_items < target) put_frame();
            while (payload_q.size() != 0) @(posedge i_clk);
        end

        while (settings_reports_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
